@@ hw/rtl/ptp_pkg.sv @@
package ptp_pkg;

    localparam int FUNC_BITS   = 2;
    localparam int HANDLE_BITS = 16;
    localparam int PERIOD_BITS = 32;
    localparam int KIND_BITS   = 2;
    localparam int FIRE_BITS   = 4;

    localparam logic [FUNC_BITS-1:0] FUNC_CREATE = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_TICK   = 2'd2;

    localparam logic [KIND_BITS-1:0] KIND_CREATE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_FIRE   = 2'd2;

    // fire results reported per tick at most
    localparam logic [FIRE_BITS-1:0] MAX_RESULTS = 4'd8;

    typedef struct packed {
        logic load;
        logic create;
        logic del_step;
        logic del_reply;
        logic tick_step;
        logic flush;
    } ptp_ctl_t;

    typedef struct packed {
        logic out_free;
        logic scan_done;
        logic hit;
        logic fire_stall;
        logic pending;
    } ptp_sts_t;

endpackage

@@ hw/rtl/ptp_cmd_if.sv @@
interface ptp_cmd_if
    import ptp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [FUNC_BITS-1:0]   func;
    logic [HANDLE_BITS-1:0] callback_id;
    logic [PERIOD_BITS-1:0] period;

    modport source (output valid, output func, output callback_id, output period,
                    input ready);
    modport sink   (input valid, input func, input callback_id, input period,
                    output ready);
endinterface

@@ hw/rtl/ptp_res_if.sv @@
interface ptp_res_if
    import ptp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [KIND_BITS-1:0]   kind;
    logic                   success;
    logic [HANDLE_BITS-1:0] fired_id;
    logic                   last;

    modport source (output valid, output kind, output success, output fired_id,
                    output last, input ready);
    modport sink   (input valid, input kind, input success, input fired_id,
                    input last, output ready);
endinterface

@@ hw/rtl/ptp_ctrl.sv @@
module ptp_ctrl
    import ptp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [FUNC_BITS-1:0] in_func,
    output logic                 in_ready,
    input  ptp_sts_t             sts,
    output ptp_ctl_t             ctl
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CREATE = 3'd1;
    localparam logic [2:0] ST_DELETE = 3'd2;
    localparam logic [2:0] ST_TICK   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    unique case (in_func)
                        FUNC_CREATE: state_next = ST_CREATE;
                        FUNC_DELETE: state_next = ST_DELETE;
                        FUNC_TICK:   state_next = ST_TICK;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CREATE:
            begin
                if (sts.out_free)
                begin
                    ctl.create = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DELETE:
            begin
                // newest first, one entry per cycle
                if (sts.scan_done || sts.hit)
                begin
                    if (sts.out_free)
                    begin
                        ctl.del_reply = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    ctl.del_step = 1'b1;
                end
            end
            ST_TICK:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!sts.fire_stall)
                begin
                    ctl.tick_step = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (!sts.pending)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    ctl.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/ptp_dp.sv @@
module ptp_dp
    import ptp_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int COUNT_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptp_ctl_t               ctl,
    output ptp_sts_t               sts,
    input  logic [HANDLE_BITS-1:0] in_id,
    input  logic [PERIOD_BITS-1:0] in_period,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [KIND_BITS-1:0]   out_kind,
    output logic                   out_success,
    output logic [HANDLE_BITS-1:0] out_id,
    output logic                   out_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = $clog2(SLOTS + 1);
    localparam logic [PW-1:0]         SLOTS_P   = PW'(SLOTS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [SLOTS-1:0]       valid_reg;
    logic [HANDLE_BITS-1:0] handle_reg [SLOTS];
    logic [PERIOD_BITS-1:0] period_reg [SLOTS];
    logic [COUNT_BITS-1:0]  count_reg  [SLOTS];
    logic [IW-1:0]          age_reg    [SLOTS];
    logic [PW-1:0]          active_reg;
    logic [PW-1:0]          pos_reg;
    logic [HANDLE_BITS-1:0] id_reg;
    logic [PERIOD_BITS-1:0] per_reg;
    logic [FIRE_BITS-1:0]   fires_reg;
    logic                   pend_reg;
    logic [HANDLE_BITS-1:0] pend_id_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [KIND_BITS-1:0]   out_kind_reg;
    logic                   out_success_reg;
    logic [HANDLE_BITS-1:0] out_id_reg;
    logic                   out_last_reg;

    logic                   out_free;
    logic                   scan_done;
    logic [PW-1:0]          ent;
    logic [IW-1:0]          ent_idx;
    logic [IW-1:0]          cur_slot;
    logic [COUNT_BITS-1:0]  cur_cnt;
    logic [COUNT_BITS-1:0]  cur_inc;
    logic                   cur_fire;
    logic                   hit;
    logic                   report;
    logic [IW-1:0]          free_idx;
    logic                   free_any;
    logic                   full;
    logic                   tick_emit;
    logic                   flush_emit;
    logic                   del_ok;

    assign out_free  = !out_valid_reg || out_ready;
    assign scan_done = (pos_reg == '0);
    assign ent       = pos_reg - 1'b1;
    assign ent_idx   = ent[IW-1:0];
    assign cur_slot  = age_reg[ent_idx];
    assign cur_cnt   = count_reg[cur_slot];
    // count saturates rather than wrapping
    assign cur_inc   = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
    assign cur_fire  = PERIOD_BITS'(cur_inc) >= period_reg[cur_slot];
    assign hit       = valid_reg[cur_slot] && (handle_reg[cur_slot] == id_reg);
    assign report    = cur_fire && (fires_reg < MAX_RESULTS);
    assign del_ok    = hit && !scan_done;
    assign tick_emit  = ctl.tick_step && report && pend_reg;
    assign flush_emit = ctl.flush && pend_reg;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!valid_reg[s])
            begin
                free_idx = IW'(s);
                free_any = 1'b1;
            end
        end
    end

    assign full = (active_reg >= SLOTS_P) || !free_any;

    assign sts.out_free   = out_free;
    assign sts.scan_done  = scan_done;
    assign sts.hit        = hit;
    // a held fire can only be pushed out when the output register has room
    assign sts.fire_stall = report && pend_reg && !out_free;
    assign sts.pending    = pend_reg;

    always_comb
    begin
        if (ctl.create || ctl.del_reply || tick_emit || flush_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            active_reg    <= '0;
            pos_reg       <= '0;
            fires_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctl.load)
            begin
                pos_reg   <= active_reg;
                fires_reg <= '0;
                pend_reg  <= 1'b0;
            end
            if (ctl.create && !full)
            begin
                valid_reg[free_idx] <= 1'b1;
                active_reg          <= active_reg + 1'b1;
            end
            if (ctl.del_reply && del_ok)
            begin
                valid_reg[cur_slot] <= 1'b0;
                active_reg          <= active_reg - 1'b1;
            end
            if (ctl.del_step)
            begin
                pos_reg <= ent;
            end
            if (ctl.tick_step)
            begin
                pos_reg <= ent;
                if (report)
                begin
                    pend_reg  <= 1'b1;
                    fires_reg <= fires_reg + 1'b1;
                end
            end
            if (ctl.flush)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            id_reg  <= in_id;
            per_reg <= in_period;
        end
        if (ctl.create && !full)
        begin
            handle_reg[free_idx]          <= id_reg;
            period_reg[free_idx]          <= per_reg;
            count_reg[free_idx]           <= '0;
            age_reg[active_reg[IW-1:0]]   <= free_idx;
        end
        if (ctl.del_reply && del_ok)
        begin
            // close the gap in the age list
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                if ((PW'(i) >= ent) && (PW'(i + 1) < active_reg))
                begin
                    age_reg[i] <= age_reg[i + 1];
                end
            end
        end
        if (ctl.tick_step)
        begin
            count_reg[cur_slot] <= cur_fire ? '0 : cur_inc;
            if (report)
            begin
                pend_id_reg <= handle_reg[cur_slot];
            end
        end
        if (ctl.create)
        begin
            out_kind_reg    <= KIND_CREATE;
            out_success_reg <= !full;
            out_id_reg      <= id_reg;
            out_last_reg    <= 1'b1;
        end
        if (ctl.del_reply)
        begin
            out_kind_reg    <= KIND_DELETE;
            out_success_reg <= del_ok;
            out_id_reg      <= id_reg;
            out_last_reg    <= 1'b1;
        end
        if (tick_emit || flush_emit)
        begin
            out_kind_reg    <= KIND_FIRE;
            out_success_reg <= 1'b1;
            out_id_reg      <= pend_id_reg;
            out_last_reg    <= flush_emit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_success = out_success_reg;
    assign out_id      = out_id_reg;
    assign out_last    = out_last_reg;

endmodule

@@ hw/rtl/periodic_timer_pool_top.sv @@
// channel | dir | handshake     | payload
// cmd     | in  | valid / ready | func, callback_id, period
// res     | out | valid / ready | kind, success, fired_id, last
//
// one request at a time; delete passes over entries newest first, and tick
// visits every active entry
// each active entry is visited by the single shared count/compare step
// reset clears the valid bits and entry count at once; no clearing pass
// a full result register holds a create or delete reply, or the tick scan at
// its next fire, until res is taken
module periodic_timer_pool_top
    import ptp_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int COUNT_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    ptp_cmd_if.sink   cmd,
    ptp_res_if.source res
);

    ptp_ctl_t ctl;
    ptp_sts_t sts;

    ptp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_func  (cmd.func),
        .in_ready (cmd.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    ptp_dp #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .in_id       (cmd.callback_id),
        .in_period   (cmd.period),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .out_kind    (res.kind),
        .out_success (res.success),
        .out_id      (res.fired_id),
        .out_last    (res.last)
    );

endmodule

@@ hw/rtl/ptp_checker.sv @@
module ptp_checker
    import ptp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cmd_valid,
    input logic                   cmd_ready,
    input logic [FUNC_BITS-1:0]   cmd_func,
    input logic                   res_valid,
    input logic                   res_ready,
    input logic [KIND_BITS-1:0]   res_kind,
    input logic                   res_success,
    input logic [HANDLE_BITS-1:0] res_fired_id,
    input logic                   res_last
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(res_kind) && $stable(res_fired_id) && $stable(res_last))
        else $error("result changed while stalled");

    // fires always report success
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_FIRE) |-> res_success)
        else $error("fire without success");

    // a create or delete reply is always marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind != KIND_FIRE) |-> res_last)
        else $error("reply not marked last");

    // a real request drops ready in the cycle after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready &&
            (cmd_func == FUNC_CREATE || cmd_func == FUNC_DELETE || cmd_func == FUNC_TICK)
            |=> !cmd_ready)
        else $error("request taken while busy");

endmodule

bind periodic_timer_pool_top ptp_checker u_ptp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_func     (cmd.func),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_kind     (res.kind),
    .res_success  (res.success),
    .res_fired_id (res.fired_id),
    .res_last     (res.last)
);
